@@ src/ima_adpcm_packet_decoder_core_assert.svh @@
// ----------------------------------------------------------------------------
// IMA ADPCM packet decoder assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IMA_ADPCM_PACKET_DECODER_CORE_ASSERT_SVH
`define IMA_ADPCM_PACKET_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IMAPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imapd check failed");
`define IMAPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imapd check failed");
`else
`define IMAPD_ASSERT_SAME(label, clk, rst, ante, cons)
`define IMAPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/imapd_pkg.sv @@
// ----------------------------------------------------------------------------
// imapd_pkg
// Widths, codes and tables shared by the IMA ADPCM packet decoder.
// ----------------------------------------------------------------------------
package imapd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int IDX_W    = 7;
   localparam int HIDX_W   = 8;
   localparam int STEP_W   = 15;
   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 4;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_DATA   = 1'b1;

   localparam logic [IDX_W-1:0]  IDX_MAX   = 7'd88;
   localparam logic [IDX_W-1:0]  IDX_RESET = 7'd15;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8001;

   localparam logic [STEP_W-1:0] STEP_SIZES [0:88] = '{
      15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
      15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
      15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107,
      15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230,
      15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494,
      15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963, 15'd1060,
      15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878, 15'd2066,
      15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660, 15'd4026,
      15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132, 15'd7845,
      15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899, 15'd15289,
      15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
      15'd32767
   };

   function automatic logic [STEP_W-1:0] step_lookup(input logic [IDX_W-1:0] idx);
      logic [STEP_W-1:0] res;
      if (idx > IDX_MAX) begin
         res = STEP_SIZES[IDX_MAX];
      end else begin
         res = STEP_SIZES[idx];
      end
      return res;
   endfunction

   function automatic logic signed [IDX_W:0] idx_adjust(input logic [2:0] mag);
      logic signed [IDX_W:0] res;
      unique case (mag)
         3'd4:    res = 8'sd2;
         3'd5:    res = 8'sd4;
         3'd6:    res = 8'sd6;
         3'd7:    res = 8'sd8;
         default: res = -8'sd1;
      endcase
      return res;
   endfunction

endpackage

@@ src/imapd_req_if.sv @@
// ----------------------------------------------------------------------------
// imapd_req_if
// Input channel: header items and compressed data bytes.
// ----------------------------------------------------------------------------
interface imapd_req_if import imapd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic signed [SAMPLE_W-1:0] header_sample;
   logic [HIDX_W-1:0]          header_step_index;
   logic signed [SAMPLE_W-1:0] header_packet_number;
   logic [BYTE_W-1:0]          data_byte;

   modport source (
      output valid, operation, header_sample, header_step_index,
             header_packet_number, data_byte,
      input  ready
   );
   modport sink (
      input  valid, operation, header_sample, header_step_index,
             header_packet_number, data_byte,
      output ready
   );
endinterface

@@ src/imapd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// imapd_rsp_if
// Result channel: two decoded samples per data byte.
// ----------------------------------------------------------------------------
interface imapd_rsp_if import imapd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] first_sample;
   logic signed [SAMPLE_W-1:0] second_sample;

   modport source (
      output valid, first_sample, second_sample,
      input  ready
   );
   modport sink (
      input  valid, first_sample, second_sample,
      output ready
   );
endinterface

@@ src/imapd_nibble.sv @@
// ----------------------------------------------------------------------------
// imapd_nibble
// One ADPCM nibble step: delta from step table, saturating predictor update,
// clamped step index update.
// ----------------------------------------------------------------------------
module imapd_nibble import imapd_pkg::*; (
   input  logic signed [SAMPLE_W-1:0] pred_cur,
   input  logic [IDX_W-1:0]           idx_cur,
   input  logic [CODE_W-1:0]          code,
   output logic signed [SAMPLE_W-1:0] pred_nxt,
   output logic [IDX_W-1:0]           idx_nxt
);

   logic [STEP_W-1:0]          step;
   logic [STEP_W+2:0]          prod;
   logic [STEP_W+1:0]          delta;
   logic signed [SAMPLE_W+1:0] pred_ext;
   logic signed [SAMPLE_W+1:0] delta_ext;
   logic signed [SAMPLE_W+1:0] sum;
   logic signed [IDX_W:0]      idx_sum;

   always_comb begin
      step      = step_lookup(idx_cur);
      prod      = {3'b000, step} * {{STEP_W{1'b0}}, code[2:0]};
      delta     = {1'b0, prod[STEP_W+2:2]} + {5'b00000, step[STEP_W-1:3]};
      pred_ext  = {{2{pred_cur[SAMPLE_W-1]}}, pred_cur};
      delta_ext = $signed({1'b0, delta});
      if (code[3]) begin
         sum = pred_ext - delta_ext;
      end else begin
         sum = pred_ext + delta_ext;
      end
      priority if (sum > $signed({{2{1'b0}}, SAMPLE_MAX})) begin
         pred_nxt = SAMPLE_MAX;
      end else if (sum < $signed({{2{1'b1}}, SAMPLE_MIN})) begin
         pred_nxt = SAMPLE_MIN;
      end else begin
         pred_nxt = sum[SAMPLE_W-1:0];
      end

      idx_sum = $signed({1'b0, idx_cur}) + idx_adjust(code[2:0]);
      priority if (idx_sum < 0) begin
         idx_nxt = '0;
      end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
         idx_nxt = IDX_MAX;
      end else begin
         idx_nxt = idx_sum[IDX_W-1:0];
      end
   end

endmodule

@@ src/ima_adpcm_packet_decoder_core.sv @@
// One item per clock sustained while results are taken; a data byte passes
// through the input register, then the result register (loaded once it is free).
// The cycle is set by the two chained nibble steps (step lookup, small multiply,
// saturating add) between the input register and the result register. Header
// items give no result and never wait on the result side.
// ----------------------------------------------------------------------------
// ima_adpcm_packet_decoder_core
// Packetised 4-bit IMA ADPCM decoder, two samples per data byte.
// ----------------------------------------------------------------------------
`include "ima_adpcm_packet_decoder_core_assert.svh"

module ima_adpcm_packet_decoder_core import imapd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   imapd_req_if.sink    req_chan,
   imapd_rsp_if.source  rsp_chan
);

   logic                       in_valid_ff, in_valid_in;
   logic                       in_op_ff;
   logic signed [SAMPLE_W-1:0] in_hsample_ff;
   logic [HIDX_W-1:0]          in_hidx_ff;
   logic signed [SAMPLE_W-1:0] in_hpkt_ff;
   logic [BYTE_W-1:0]          in_data_ff;

   logic signed [SAMPLE_W-1:0] predictor_ff, predictor_in;
   logic [IDX_W-1:0]           step_index_ff, step_index_in;
   logic signed [SAMPLE_W-1:0] last_pkt_ff, last_pkt_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_first_ff, rsp_second_ff;

   logic                       req_take;
   logic                       stage_go;
   logic                       rsp_load;
   logic                       rsp_free;
   logic signed [SAMPLE_W:0]   pkt_diff;

   logic signed [SAMPLE_W-1:0] pred_mid, pred_end;
   logic [IDX_W-1:0]           idx_mid, idx_end;

   imapd_nibble u_nib_lo (
      .pred_cur (predictor_ff),
      .idx_cur  (step_index_ff),
      .code     (in_data_ff[CODE_W-1:0]),
      .pred_nxt (pred_mid),
      .idx_nxt  (idx_mid)
   );

   imapd_nibble u_nib_hi (
      .pred_cur (pred_mid),
      .idx_cur  (idx_mid),
      .code     (in_data_ff[BYTE_W-1:CODE_W]),
      .pred_nxt (pred_end),
      .idx_nxt  (idx_end)
   );

   always_comb begin
      rsp_free       = !rsp_valid_ff || rsp_chan.ready;
      stage_go       = in_valid_ff && ((in_op_ff == OP_HEADER) || rsp_free);
      rsp_load       = stage_go && (in_op_ff == OP_DATA);
      req_chan.ready = !in_valid_ff || stage_go;
      req_take       = req_chan.valid && req_chan.ready;
      in_valid_in    = req_take || (in_valid_ff && !stage_go);
      rsp_valid_in   = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

      pkt_diff      = {in_hpkt_ff[SAMPLE_W-1], in_hpkt_ff}
                      - {last_pkt_ff[SAMPLE_W-1], last_pkt_ff};
      predictor_in  = predictor_ff;
      step_index_in = step_index_ff;
      last_pkt_in   = last_pkt_ff;
      if (stage_go) begin
         if (in_op_ff == OP_HEADER) begin
            if (pkt_diff != 17'sd1) begin
               predictor_in = in_hsample_ff;
            end
            last_pkt_in = in_hpkt_ff;
            if (in_hidx_ff > {1'b0, IDX_MAX}) begin
               step_index_in = IDX_MAX;
            end else begin
               step_index_in = in_hidx_ff[IDX_W-1:0];
            end
         end else begin
            predictor_in  = pred_end;
            step_index_in = idx_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         predictor_ff  <= '0;
         step_index_ff <= IDX_RESET;
         last_pkt_ff   <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         predictor_ff  <= predictor_in;
         step_index_ff <= step_index_in;
         last_pkt_ff   <= last_pkt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff      <= req_chan.operation;
         in_hsample_ff <= req_chan.header_sample;
         in_hidx_ff    <= req_chan.header_step_index;
         in_hpkt_ff    <= req_chan.header_packet_number;
         in_data_ff    <= req_chan.data_byte;
      end
      if (rsp_load) begin
         rsp_first_ff  <= pred_mid;
         rsp_second_ff <= pred_end;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.first_sample  = rsp_first_ff;
   assign rsp_chan.second_sample = rsp_second_ff;

   `IMAPD_ASSERT_SAME(a_idx_range, clock, reset, 1'b1, step_index_ff <= IDX_MAX)
   `IMAPD_ASSERT_NEXT(a_pred_sat, clock, reset, rsp_load, predictor_ff != 16'sh8000)
   `IMAPD_ASSERT_NEXT(a_rsp_loaded, clock, reset, rsp_load, rsp_valid_ff)
   `IMAPD_ASSERT_NEXT(a_req_held, clock, reset, req_take, in_valid_ff)

endmodule
